@@ rtl/core/linear_probe_hash_table_unit_assert.svh @@
// Assertion macros for the linear probing hash table unit.
// Included by the top level; expects signals clk and rst in scope.
`ifndef LINEAR_PROBE_HASH_TABLE_UNIT_ASSERT_SVH
`define LINEAR_PROBE_HASH_TABLE_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LPHT_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LPHT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/lpht_pkg.sv @@
// Package for the linear probing hash table unit.
// Holds field widths, operation and status codes and the sequencer states.
`default_nettype none

package lpht_pkg;

  localparam int KEY_W            = 31;
  localparam int TYPE_W           = 2;
  localparam int STATUS_W         = 2;
  localparam int SLOT_W           = 4;
  localparam int DEF_TABLE_SIZE   = 16;

  typedef enum logic [TYPE_W-1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_SEARCH = 2'd2
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_MISSING = 2'd1,
    ST_FULL    = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_MOD,
    S_PROBE,
    S_DONE
  } state_t;

endpackage

`default_nettype wire

@@ rtl/core/lpht_req_if.sv @@
// Request and response channel interfaces of the hash table unit.
// Depends on lpht_pkg for the field widths.
`default_nettype none

interface lpht_req_if
  import lpht_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [TYPE_W-1:0] req_type;
  logic [KEY_W-1:0]  key;

  modport source (output valid, output req_type, output key, input ready);
  modport sink (input valid, input req_type, input key, output ready);
endinterface

interface lpht_rsp_if
  import lpht_pkg::*;
  ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [SLOT_W-1:0]   slot;

  modport source (output valid, output status, output slot, input ready);
  modport sink (input valid, input status, input slot, output ready);
endinterface

`default_nettype wire

@@ rtl/core/linear_probe_hash_table_unit.sv @@
// Linear probing hash table unit. A request passes through the remainder unit,
// then probes the table from the home slot on, at most TABLE_SIZE slots, one
// slot probed per cycle, and then loads the response register.
// A new request can be taken in the cycle after the response register is loaded.
// After reset the unit sweeps the table memory, marking every slot empty, and
// accepts no transaction until the sweep is complete.
`default_nettype none

module linear_probe_hash_table_unit
  import lpht_pkg::*;
#(
  parameter int TABLE_SIZE = DEF_TABLE_SIZE
) (
  input  wire logic  clk,
  input  wire logic  rst,
  lpht_req_if.sink   req,
  lpht_rsp_if.source rsp
);

  `include "linear_probe_hash_table_unit_assert.svh"

  localparam int IDX_W = $clog2(TABLE_SIZE);
  localparam logic [IDX_W-1:0] LAST = IDX_W'(TABLE_SIZE - 1);

  state_t state;
  state_t state_next;

  logic [TYPE_W-1:0]   op_r;
  logic [KEY_W-1:0]    key_r;
  logic [IDX_W-1:0]    idx;
  logic [IDX_W-1:0]    probe_cnt;
  logic [IDX_W-1:0]    idx_wrap;

  logic                rem_done;
  logic [IDX_W-1:0]    rem_val;

  logic [KEY_W:0]      table_mem [TABLE_SIZE];
  logic [KEY_W:0]      rd_data;
  logic [IDX_W-1:0]    rd_addr;
  logic                wr_en;
  logic [IDX_W-1:0]    wr_addr;
  logic [KEY_W:0]      wr_data;

  logic                accept;
  logic                is_insert;
  logic                hit;
  logic                probe_end;

  logic [STATUS_W-1:0] res_status;
  logic [IDX_W-1:0]    res_slot;
  logic                rsp_valid;
  logic [STATUS_W-1:0] rsp_status;
  logic [SLOT_W-1:0]   rsp_slot;
  logic [SLOT_W+IDX_W-1:0] slot_ext;

  assign accept    = req.valid && req.ready;
  assign req.ready = (state == S_IDLE);
  assign rsp.valid  = rsp_valid;
  assign rsp.status = rsp_status;
  assign rsp.slot   = rsp_slot;

  lpht_rem #(
    .TABLE_SIZE(TABLE_SIZE)
  ) u_rem (
    .clk  (clk),
    .rst  (rst),
    .start(accept),
    .key  (req.key),
    .done (rem_done),
    .rem  (rem_val)
  );

  always_comb begin
    idx_wrap  = (idx == LAST) ? '0 : idx + 1'b1;
    is_insert = (op_r == OP_INSERT);
    hit       = is_insert ? !rd_data[KEY_W] : (rd_data[KEY_W] && rd_data[KEY_W-1:0] == key_r);
    probe_end = hit || (probe_cnt == LAST);
  end

  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: begin
        if (idx == LAST) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (req.valid) state_next = S_MOD;
      end
      S_MOD: begin
        if (rem_done) state_next = S_PROBE;
      end
      S_PROBE: begin
        if (probe_end) state_next = S_DONE;
      end
      S_DONE: begin
        if (!rsp_valid || rsp.ready) state_next = S_IDLE;
      end
      default: state_next = S_CLEAR;
    endcase
  end

  always_comb begin
    rd_addr = idx_wrap;
    wr_en   = 1'b0;
    wr_addr = idx;
    wr_data = {1'b0, key_r};
    case (state)
      S_CLEAR: begin
        wr_en   = 1'b1;
        wr_data = '0;
      end
      S_MOD: begin
        rd_addr = rem_val;
      end
      S_PROBE: begin
        if (hit && op_r == OP_INSERT) begin
          wr_en   = 1'b1;
          wr_data = {1'b1, key_r};
        end else if (hit && op_r == OP_REMOVE) begin
          wr_en   = 1'b1;
        end
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      idx       <= '0;
      probe_cnt <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        S_CLEAR: begin
          idx <= idx_wrap;
        end
        S_MOD: begin
          if (rem_done) begin
            idx       <= rem_val;
            probe_cnt <= '0;
          end
        end
        S_PROBE: begin
          if (!probe_end) begin
            idx       <= idx_wrap;
            probe_cnt <= probe_cnt + 1'b1;
          end
        end
        default: begin
          idx <= idx;
        end
      endcase
      if (state == S_DONE && (!rsp_valid || rsp.ready)) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  assign slot_ext = {{SLOT_W{1'b0}}, res_slot};

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r  <= req.req_type;
      key_r <= req.key;
    end
    if (state == S_PROBE && probe_end) begin
      if (hit) begin
        res_status <= ST_OK;
        res_slot   <= idx;
      end else begin
        res_status <= is_insert ? ST_FULL : ST_MISSING;
        res_slot   <= '0;
      end
    end
    if (state == S_DONE && (!rsp_valid || rsp.ready)) begin
      rsp_status <= res_status;
      rsp_slot   <= slot_ext[SLOT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      table_mem[wr_addr] <= wr_data;
    end
    rd_data <= table_mem[rd_addr];
  end

  `LPHT_ASSERT_SAME(a_miss_slot_zero, rsp.valid && rsp.status != ST_OK, rsp.slot == '0, "Response with a failing status carries a nonzero slot.")
  `LPHT_ASSERT_NEXT(a_accept_starts, accept, state == S_MOD && !rem_done, "Accepted request did not start the remainder unit.")
  `LPHT_ASSERT_SAME(a_full_on_insert, state == S_DONE && res_status == ST_FULL, op_r == OP_INSERT, "Table full reported for an operation other than insert.")
  `LPHT_ASSERT_SAME(a_done_in_mod, rem_done, state == S_MOD, "Remainder finished outside the remainder phase.")

endmodule

`default_nettype wire

@@ rtl/core/lpht_rem.sv @@
// Remainder unit: key modulo the table size by reciprocal multiplication, registered through stage1, stage2 and done.
// Depends on lpht_pkg for the key width.
`default_nettype none

module lpht_rem
  import lpht_pkg::*;
#(
  parameter int TABLE_SIZE = DEF_TABLE_SIZE
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic [KEY_W-1:0]              key,
  output logic                               done,
  output logic [$clog2(TABLE_SIZE)-1:0]      rem
);

  localparam int IDX_W   = $clog2(TABLE_SIZE);
  localparam int RECIP_W = 32;
  localparam int PROD_W  = KEY_W + RECIP_W;
  localparam int SHIFT   = KEY_W + IDX_W;
  // The reciprocal is rounded up with KEY_W + IDX_W fraction bits, which makes the
  // quotient exact for every key. Only the low bits of the quotient are needed,
  // since the remainder is below 2**IDX_W.
  localparam logic [63:0] RECIP_FULL =
    ((64'd1 << SHIFT) + 64'(TABLE_SIZE) - 64'd1) / 64'(TABLE_SIZE);
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_FULL);
  localparam logic [IDX_W-1:0] N_LO = IDX_W'(TABLE_SIZE);

  logic               stage1;
  logic               stage2;
  logic [KEY_W-1:0]   key_q;
  logic [IDX_W-1:0]   key_lo;
  logic [IDX_W-1:0]   quot_lo;
  logic [PROD_W-1:0]  prod;
  logic [2*IDX_W-1:0] back_prod;
  logic [IDX_W-1:0]   rem_next;

  always_comb begin
    prod      = PROD_W'(key_q) * PROD_W'(RECIP);
    back_prod = (2*IDX_W)'(quot_lo) * (2*IDX_W)'(N_LO);
    rem_next  = key_lo - back_prod[IDX_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage1 <= 1'b0;
      stage2 <= 1'b0;
      done   <= 1'b0;
    end else begin
      stage1 <= start;
      stage2 <= stage1;
      done   <= stage2;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      key_q <= key;
    end
    if (stage1) begin
      quot_lo <= prod[SHIFT +: IDX_W];
      key_lo  <= key_q[IDX_W-1:0];
    end
    if (stage2) begin
      rem <= rem_next;
    end
  end

endmodule

`default_nettype wire
